FILE: rtl/sie_pkg.sv
// ----------------------------------------------------------------------------
// sie_pkg
// Shared types and codes for the sorted insert and emit block.
// ----------------------------------------------------------------------------
package sie_pkg;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               last;
  } out_t;

  typedef struct packed {
    logic load_we;
    logic ins_start;
    logic scan_rd;
    logic pos_dec;
    logic emit_new;
    logic emit_rd;
    logic emit_mem;
    logic clr_count;
  } cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic less;
    logic at_pos;
    logic more;
    logic last_new;
    logic last_mem;
  } sts_t;

endpackage

FILE: rtl/sie_ctrl.sv
// ----------------------------------------------------------------------------
// sie_ctrl
// Sequencer for loads, the downward scan and the merged emit.
// ----------------------------------------------------------------------------
module sie_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          req_type,
  input  sie_pkg::sts_t sts,
  output sie_pkg::cmd_t cmd,
  output logic          busy
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN_CHK = 3'd1;
  localparam logic [2:0] ST_SCAN_CMP = 3'd2;
  localparam logic [2:0] ST_EMIT_CHK = 3'd3;
  localparam logic [2:0] ST_EMIT_OUT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (req_type == sie_pkg::REQ_INSERT) begin
            cmd.ins_start = 1'b1;
            state_nxt     = ST_SCAN_CHK;
          end else begin
            cmd.load_we = 1'b1;
          end
        end
      end
      ST_SCAN_CHK: begin
        if (sts.pos_zero) begin
          state_nxt = ST_EMIT_CHK;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (sts.less) begin
          cmd.pos_dec = 1'b1;
          state_nxt   = ST_SCAN_CHK;
        end else begin
          state_nxt = ST_EMIT_CHK;
        end
      end
      ST_EMIT_CHK: begin
        priority if (sts.at_pos) begin
          cmd.emit_new = 1'b1;
          if (sts.last_new) begin
            cmd.clr_count = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (sts.more) begin
          cmd.emit_rd = 1'b1;
          state_nxt   = ST_EMIT_OUT;
        end else begin
          cmd.clr_count = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_EMIT_OUT: begin
        cmd.emit_mem = 1'b1;
        if (sts.last_mem) begin
          cmd.clr_count = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT_CHK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: rtl/sie_datapath.sv
// ----------------------------------------------------------------------------
// sie_datapath
// Element store, count, scan position, emit index and result register.
// ----------------------------------------------------------------------------
module sie_datapath #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] in_value,
  input  sie_pkg::cmd_t      cmd,
  output sie_pkg::sts_t      sts,
  output logic               out_strobe,
  output sie_pkg::out_t      out_item
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic signed [31:0] mem [0:DEPTH-1];
  logic signed [31:0] rd_data_r;
  logic signed [31:0] ins_val_r;
  logic [CNT_W-1:0]   count_r,   count_nxt;
  logic [CNT_W-1:0]   pos_r,     pos_nxt;
  logic [CNT_W-1:0]   idx_r,     idx_nxt;
  logic               ins_done_r, ins_done_nxt;
  logic               out_vld_r,  out_vld_nxt;
  sie_pkg::out_t      out_item_r;
  logic [CNT_W-1:0]   pos_m1;
  logic [CNT_W-1:0]   rd_sel;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_en;

  assign pos_m1  = pos_r - ONE_C;
  assign rd_sel  = cmd.scan_rd ? pos_m1 : idx_r;
  assign rd_addr = rd_sel[IDX_W-1:0];
  assign wr_addr = count_r[IDX_W-1:0];
  assign wr_en   = cmd.load_we && (count_r < DEPTH_C);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    if (cmd.scan_rd || cmd.emit_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    idx_nxt      = idx_r;
    ins_done_nxt = ins_done_r;
    out_vld_nxt  = cmd.emit_new || cmd.emit_mem;
    if (wr_en) begin
      count_nxt = count_r + ONE_C;
    end
    if (cmd.ins_start) begin
      pos_nxt      = count_r;
      idx_nxt      = '0;
      ins_done_nxt = 1'b0;
    end
    if (cmd.pos_dec) begin
      pos_nxt = pos_m1;
    end
    if (cmd.emit_new) begin
      ins_done_nxt = 1'b1;
    end
    if (cmd.emit_mem) begin
      idx_nxt = idx_r + ONE_C;
    end
    if (cmd.clr_count) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      pos_r      <= '0;
      idx_r      <= '0;
      ins_done_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      pos_r      <= pos_nxt;
      idx_r      <= idx_nxt;
      ins_done_r <= ins_done_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_start) begin
      ins_val_r <= in_value;
    end
    if (cmd.emit_new) begin
      out_item_r.out_value <= ins_val_r;
      out_item_r.last      <= sts.last_new;
    end else if (cmd.emit_mem) begin
      out_item_r.out_value <= rd_data_r;
      out_item_r.last      <= sts.last_mem;
    end
  end

  assign sts.pos_zero = (pos_r == '0);
  assign sts.less     = (ins_val_r < rd_data_r);
  assign sts.at_pos   = !ins_done_r && (idx_r == pos_r);
  assign sts.more     = (idx_r < count_r);
  assign sts.last_new = (idx_r == count_r);
  assign sts.last_mem = ins_done_r && ((idx_r + ONE_C) == count_r);

  assign out_strobe = out_vld_r;
  assign out_item   = out_item_r;

endmodule

FILE: rtl/sorted_insert_emit.sv
// ----------------------------------------------------------------------------
// sorted_insert_emit
// Buffered list with ordered insertion of one value and a full emit.
// ----------------------------------------------------------------------------
// Input: a transaction is taken when start is high and busy is low.
//   req_type load appends value to the store (dropped when DEPTH are held);
//   busy stays low, so loads may come every cycle.
//   req_type insert scans the store from the newest entry down while the
//   new value is smaller, then emits the list oldest first with the new
//   value placed after the last entry not greater than it. The store is
//   empty afterwards.
// Output: each result is on out_item for one cycle with out_strobe high;
//   the final one has last set. The receiver cannot stall the block.
// Timing: an insert keeps busy high through the scan and the emit; the
//   first result follows the scan. Each entry passed by the scan or
//   emitted from the store is read through the single registered read
//   port of the element store, shared by the scan and the emit.
// Reset: rst_n clears the count and the sequencer; store contents are kept
//   but unreachable until reloaded.
// ----------------------------------------------------------------------------
module sorted_insert_emit #(
  parameter int DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sie_pkg::in_t  in_item,
  output logic          out_strobe,
  output sie_pkg::out_t out_item
);

  sie_pkg::cmd_t cmd;
  sie_pkg::sts_t sts;

  sie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_item.req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  sie_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_item.value),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last) |-> !busy)
    else $error("block still busy after the final result");

  a_more_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last) |-> busy)
    else $error("block idle before the final result");

endmodule
